>>> rtl/sps_pkg.sv
package sps_pkg;

  localparam int unsigned MAX_MESSAGE_BYTES_DEF = 128;

  // Configuration register indexes.
  localparam logic [1:0] REG_MESSAGE_LENGTH = 2'd0;
  localparam logic [1:0] REG_TARGET_NIBBLES = 2'd1;
  localparam logic [1:0] REG_TARGET_VALUE   = 2'd2;
  localparam logic [1:0] REG_MAX_ATTEMPTS   = 2'd3;

  // Input function codes.
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // Result status codes.
  localparam logic STATUS_MATCH     = 1'b0;
  localparam logic STATUS_EXHAUSTED = 1'b1;

  typedef struct packed {
    logic        func;
    logic [7:0]  data_byte;
    logic [63:0] seed_nonce;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [63:0] nonce;
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last;
  } out_item_t;

  typedef logic [31:0] word_t;

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    k = 32'h0;
    case (t)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic word_t initial_hash(input logic [2:0] i);
    word_t h;
    h = 32'h0;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
      default: h = 32'h0;
    endcase
    return h;
  endfunction

endpackage

>>> rtl/sps_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module sps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/sps_sched_cell.sv
// One cell of the message schedule shift chain. Each cell holds one word
// and hands it to its neighbor every cycle that the chain shifts.
module sps_sched_cell (
  input  logic               clk,
  input  logic               shift,
  input  sps_pkg::word_t     word_in,
  output sps_pkg::word_t     word_out
);

  sps_pkg::word_t word_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      word_r <= word_in;
    end
  end

  assign word_out = word_r;

endmodule

>>> rtl/sps_round_cell.sv
// One cell of the working-variable chain. Cells a and e take the freshly
// computed round values; every other cell takes its neighbor's word.
// On load the cell takes an external value (the chaining hash).
module sps_round_cell (
  input  logic           clk,
  input  logic           load,
  input  logic           shift,
  input  sps_pkg::word_t load_val,
  input  sps_pkg::word_t word_in,
  output sps_pkg::word_t word_out
);

  sps_pkg::word_t word_r;

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= load_val;
    end else if (shift) begin
      word_r <= word_in;
    end
  end

  assign word_out = word_r;

endmodule

>>> rtl/sha256_prefix_nonce_search.sv
// SHA-256 prefix nonce search.
// Input channel (in_valid/in_stall/in_item): a transaction with func load
// writes data_byte into the message store at the load pointer and leaves
// the block ready for the next one. A transaction with func search seeds the
// nonce with seed_nonce, then for each attempt increments it, writes it
// little-endian into the last eight message bytes and hashes message_length
// bytes with SHA-256. Each 64-byte block passes through a chain of 8 working
// word cells and 16 schedule cells: an init step, 16 fill rounds that each
// read four bytes from the message RAM (registered read data), the remaining
// rounds at one round per cycle, and an add step. An attempt has a start
// step, eight nonce byte writes, its blocks (1 to 3 of them) and a check.
// Results: four transactions on out_* for a match (word_index 0..3, last on
// the fourth) or one with status exhausted after max_attempts attempts.
// The result register holds its item while out_stall is high; the search
// waits until each result is taken. in_stall is high from the search
// transaction until its last result is taken.
// Reset (rst_n low, synchronous) restores the register defaults and clears
// the pointers; the message RAM is undefined until written.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready.
module sha256_prefix_nonce_search #(
  parameter int unsigned MAX_MESSAGE_BYTES = sps_pkg::MAX_MESSAGE_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sps_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output sps_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  localparam int unsigned AW = $clog2(MAX_MESSAGE_BYTES);
  localparam logic [7:0] MAXB = 8'(MAX_MESSAGE_BYTES);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_NONCE  = 4'd1;
  localparam logic [3:0] ST_BINIT  = 4'd2;
  localparam logic [3:0] ST_FILL   = 4'd3;
  localparam logic [3:0] ST_ROUND  = 4'd4;
  localparam logic [3:0] ST_ADD    = 4'd5;
  localparam logic [3:0] ST_CHECK  = 4'd6;
  localparam logic [3:0] ST_EMIT   = 4'd7;
  localparam logic [3:0] ST_EXH    = 4'd8;
  localparam logic [3:0] ST_START  = 4'd9;

  // Configuration registers.
  logic [6:0]  msg_len_r;
  logic [4:0]  tgt_nib_r;
  logic [63:0] tgt_val_r;
  logic [31:0] max_att_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_len_r <= 7'd106;
      tgt_nib_r <= 5'd4;
      tgt_val_r <= 64'd2443202797848494080;
      max_att_r <= 32'hffffffff;
    end else if (cfg_valid) begin
      case (cfg_index)
        sps_pkg::REG_MESSAGE_LENGTH: msg_len_r <= cfg_data[6:0];
        sps_pkg::REG_TARGET_NIBBLES: tgt_nib_r <= cfg_data[4:0];
        sps_pkg::REG_TARGET_VALUE:   tgt_val_r <= cfg_data;
        sps_pkg::REG_MAX_ATTEMPTS:   max_att_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Effective length and match mask.
  logic [7:0]  len;
  logic [4:0]  nib;
  logic [63:0] mask;
  logic [7:0]  total;
  logic [8:0]  len9;

  always_comb begin
    len = {1'b0, msg_len_r};
    if (len < 8'd9) begin
      len = 8'd9;
    end
    if (len > MAXB) begin
      len = MAXB;
    end
    nib = (tgt_nib_r > 5'd16) ? 5'd16 : tgt_nib_r;
    mask = (nib == 5'd0) ? 64'd0 : ~64'd0 << (7'd64 - {nib, 2'b00});
    len9 = {1'b0, len} + 9'd72;
    total = {len9[8:6], 6'd0} > 9'd255 ? 8'd192 : 8'({len9[8:6], 6'd0});
  end

  // Control state.
  logic [3:0]  state_r, state_nxt;
  logic [AW-1:0] ptr_r;
  logic [63:0] nonce_r;
  logic [31:0] att_r;
  logic [7:0]  base_r;
  logic [6:0]  rnd_r;
  logic [3:0]  sub_r;
  logic [1:0]  widx_r;
  logic        out_valid_r;
  sps_pkg::out_item_t out_r;

  // Message RAM.
  logic          ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [7:0]    ram_wd, ram_rd;

  sps_ram #(.WIDTH(8), .DEPTH(MAX_MESSAGE_BYTES)) u_msg (
    .clk(clk), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
    .rd_addr(ram_ra), .rd_data(ram_rd)
  );

  // Hash words.
  sps_pkg::word_t h_r [8];

  // Padded byte position being read during fill.
  logic [7:0] pos;
  logic [7:0] pos_q_r;
  logic [7:0] pad_byte;
  logic [10:0] bits;
  logic [7:0] from_end;

  assign pos = base_r + {2'b00, rnd_r[3:0], 2'b00} + {4'd0, sub_r};
  assign ram_ra = pos[AW-1:0];
  assign bits = {len, 3'b000};

  always_comb begin
    from_end = total - 8'd1 - pos_q_r;
    if (pos_q_r < len) begin
      pad_byte = ram_rd;
    end else if (pos_q_r == len) begin
      pad_byte = 8'h80;
    end else if (from_end == 8'd0) begin
      pad_byte = bits[7:0];
    end else if (from_end == 8'd1) begin
      pad_byte = {5'd0, bits[10:8]};
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Schedule word being assembled from bytes.
  logic [31:0] wacc_r;
  logic [31:0] wfill;
  assign wfill = {wacc_r[23:0], pad_byte};

  // Schedule chain: sw[0] oldest (t-16), sw[15] newest (t-1).
  sps_pkg::word_t sw [16];
  sps_pkg::word_t sw_in [16];
  logic sched_shift;
  sps_pkg::word_t wnew, w_cur, s0w, s1w;

  always_comb begin
    s0w = {sw[1][6:0], sw[1][31:7]} ^ {sw[1][17:0], sw[1][31:18]} ^ (sw[1] >> 3);
    s1w = {sw[14][16:0], sw[14][31:17]} ^ {sw[14][18:0], sw[14][31:19]} ^ (sw[14] >> 10);
    wnew = sw[0] + s0w + sw[9] + s1w;
  end

  genvar g;
  generate
    for (g = 0; g < 16; g++) begin : g_sched
      if (g == 15) begin : g_top
        assign sw_in[g] = w_cur;
      end else begin : g_mid
        assign sw_in[g] = sw[g+1];
      end
      sps_sched_cell u_cell (.clk(clk), .shift(sched_shift), .word_in(sw_in[g]),
                             .word_out(sw[g]));
    end
  endgenerate

  // Working variable chain a..h.
  sps_pkg::word_t v [8];
  sps_pkg::word_t v_in [8];
  logic v_load, v_shift;
  sps_pkg::word_t t1, t2, bs0, bs1, ch, mj;

  always_comb begin
    bs1 = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]} ^ {v[4][24:0], v[4][31:25]};
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + bs1 + ch + sps_pkg::round_k(rnd_r[5:0]) + w_cur;
    bs0 = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]} ^ {v[0][21:0], v[0][31:22]};
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = bs0 + mj;
  end

  generate
    for (g = 0; g < 8; g++) begin : g_work
      if (g == 0) begin : g_a
        assign v_in[g] = t1 + t2;
      end else if (g == 4) begin : g_e
        assign v_in[g] = v[3] + t1;
      end else begin : g_mid
        assign v_in[g] = v[g-1];
      end
      sps_round_cell u_cell (.clk(clk), .load(v_load), .shift(v_shift),
                             .load_val(h_r[g]), .word_in(v_in[g]), .word_out(v[g]));
    end
  endgenerate

  logic fill_done;
  assign fill_done = (sub_r == 4'd4);
  assign w_cur = (rnd_r < 7'd16) ? wfill : wnew;

  // Sequencer.
  logic in_acc, out_acc, hit;
  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;
  assign hit = ((({h_r[0], h_r[1]}) ^ tgt_val_r) & mask) == 64'd0;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item = out_r;

  // Slice loaded into the result register: the next one once the current is taken.
  logic [1:0] emit_idx;
  assign emit_idx = out_acc ? widx_r + 2'd1 : widx_r;

  logic [2:0] nb_r;

  always_comb begin
    state_nxt = state_r;
    ram_we = 1'b0;
    ram_wa = ptr_r;
    ram_wd = in_item.data_byte;
    sched_shift = 1'b0;
    v_load = 1'b0;
    v_shift = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_item.func == sps_pkg::FUNC_LOAD) begin
          ram_we = 1'b1;
        end else if (in_acc) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        state_nxt = ({32'd0, att_r} < {32'd0, max_att_r}) ? ST_NONCE : ST_EXH;
      end
      ST_NONCE: begin
        ram_we = 1'b1;
        ram_wa = AW'(len - 8'd8 + {5'd0, nb_r});
        ram_wd = nonce_r[{nb_r, 3'b000} +: 8];
        if (nb_r == 3'd7) begin
          state_nxt = ST_BINIT;
        end
      end
      ST_BINIT: begin
        v_load = 1'b1;
        state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (fill_done) begin
          sched_shift = 1'b1;
          v_shift = 1'b1;
          state_nxt = (rnd_r == 7'd15) ? ST_ROUND : ST_FILL;
        end
      end
      ST_ROUND: begin
        sched_shift = 1'b1;
        v_shift = 1'b1;
        if (rnd_r == 7'd63) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        state_nxt = (base_r + 8'd64 < total) ? ST_BINIT : ST_CHECK;
      end
      ST_CHECK: begin
        if (hit) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_START;
        end
      end
      ST_EMIT: begin
        if (out_acc && widx_r == 2'd3) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EXH: begin
        if (out_acc) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ptr_r <= '0;
      nonce_r <= 64'd0;
      att_r <= 32'd0;
      out_valid_r <= 1'b0;
      base_r <= 8'd0;
      rnd_r <= 7'd0;
      sub_r <= 4'd0;
      nb_r <= 3'd0;
      widx_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (out_acc) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc && in_item.func == sps_pkg::FUNC_LOAD) begin
            ptr_r <= (ptr_r == AW'(MAX_MESSAGE_BYTES - 1)) ? '0 : ptr_r + 1'b1;
          end else if (in_acc) begin
            nonce_r <= in_item.seed_nonce;
            att_r <= 32'd0;
          end
        end
        ST_START: begin
          nb_r <= 3'd0;
          base_r <= 8'd0;
          if ({32'd0, att_r} < {32'd0, max_att_r}) begin
            att_r <= att_r + 32'd1;
            nonce_r <= nonce_r + 64'd1;
          end
        end
        ST_NONCE: begin
          nb_r <= nb_r + 3'd1;
        end
        ST_BINIT: begin
          rnd_r <= 7'd0;
          sub_r <= 4'd0;
        end
        ST_FILL: begin
          if (fill_done) begin
            sub_r <= 4'd0;
            rnd_r <= rnd_r + 7'd1;
          end else begin
            sub_r <= sub_r + 4'd1;
          end
          pos_q_r <= pos;
          if (sub_r != 4'd0) begin
            wacc_r <= wfill;
          end
        end
        ST_ROUND: begin
          rnd_r <= rnd_r + 7'd1;
        end
        ST_ADD: begin
          base_r <= base_r + 8'd64;
          widx_r <= 2'd0;
        end
        ST_EMIT: begin
          if (!out_valid_r || out_acc) begin
            if (!(out_acc && widx_r == 2'd3) && !(out_valid_r && !out_acc)) begin
              out_valid_r <= 1'b1;
              out_r.status <= sps_pkg::STATUS_MATCH;
              out_r.nonce <= nonce_r;
              out_r.digest_word <= {h_r[{emit_idx, 1'b0}], h_r[{emit_idx, 1'b1}]};
              out_r.word_index <= emit_idx;
              out_r.last <= (emit_idx == 2'd3);
            end
          end
          if (out_acc) begin
            widx_r <= widx_r + 2'd1;
          end
        end
        ST_EXH: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            out_r.status <= sps_pkg::STATUS_EXHAUSTED;
            out_r.nonce <= nonce_r;
            out_r.digest_word <= 64'd0;
            out_r.word_index <= 2'd0;
            out_r.last <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Chaining hash: reset per attempt at the first block, accumulated after each.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      if (state_r == ST_START) begin
        h_r[i] <= sps_pkg::initial_hash(3'(i));
      end else if (state_r == ST_ADD) begin
        h_r[i] <= h_r[i] + v[i];
      end
    end
  end

endmodule

>>> rtl/sps_checker.sv
// Port-level checks for the nonce search block.
module sps_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input sps_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input sps_pkg::out_item_t out_item
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // A stalled input transaction stays offered with the same payload.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input changed");

  // An exhausted result is always the final one with zero digest.
  a_exh_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == sps_pkg::STATUS_EXHAUSTED |->
      out_item.last && out_item.digest_word == 64'd0)
    else $error("malformed exhausted result");

  // Match results carry last only on the fourth slice.
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == sps_pkg::STATUS_MATCH |->
      (out_item.last == (out_item.word_index == 2'd3)))
    else $error("last flag disagrees with word index");

  // No input is taken while a result is pending.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted during result delivery");

endmodule

bind sha256_prefix_nonce_search sps_checker u_sps_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .in_item(in_item), .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);

>>> bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 60000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int TARGET_ITEMS = 500;

  // Predicts the block: message store, registers and the SHA-256 search.
  class nonce_search_scoreboard;
    logic [7:0]  store [128];
    bit          written [128];
    logic [6:0]  load_ptr;
    logic [6:0]  msg_len;
    logic [4:0]  nibbles;
    logic [63:0] target;
    logic [31:0] attempt_limit;
    sps_pkg::out_item_t expected_q [$];
    int          errors;

    function new();
      load_ptr = '0;
      msg_len = 7'd106;
      nibbles = 5'd4;
      target = 64'd2443202797848494080;
      attempt_limit = 32'hFFFF_FFFF;
      errors = 0;
      foreach (written[i]) written[i] = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] value);
      case (idx)
        sps_pkg::REG_MESSAGE_LENGTH: msg_len = value[6:0];
        sps_pkg::REG_TARGET_NIBBLES: nibbles = value[4:0];
        sps_pkg::REG_TARGET_VALUE:   target = value;
        sps_pkg::REG_MAX_ATTEMPTS:   attempt_limit = value[31:0];
        default: ;
      endcase
    endfunction

    // Longest message length whose loaded part has been written.
    function int longest_safe_length();
      int k;
      k = 0;
      while (k < 128 && written[k]) k++;
      return (k + 8 > 127) ? 127 : k + 8;
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    // Standard SHA-256 over the first len bytes of the store.
    function logic [255:0] sha256_of_store(int len);
      logic [7:0]  padded [192];
      logic [31:0] h [8];
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
      logic [63:0] bit_len;
      int total;
      total = ((len + 72) / 64) * 64;
      bit_len = 64'(len) * 8;
      for (int p = 0; p < total; p++) begin
        if (p < len) padded[p] = store[p];
        else if (p == len) padded[p] = 8'h80;
        else if (p + 8 >= total) padded[p] = bit_len[8 * (total - 1 - p) +: 8];
        else padded[p] = 8'h00;
      end
      for (int i = 0; i < 8; i++) h[i] = sps_pkg::initial_hash(3'(i));
      for (int base = 0; base < total; base += 64) begin
        for (int t = 0; t < 64; t++) begin
          if (t < 16) begin
            w[t] = {padded[base + 4 * t], padded[base + 4 * t + 1],
                    padded[base + 4 * t + 2], padded[base + 4 * t + 3]};
          end else begin
            s0 = rotr(w[t - 15], 7) ^ rotr(w[t - 15], 18) ^ (w[t - 15] >> 3);
            s1 = rotr(w[t - 2], 17) ^ rotr(w[t - 2], 19) ^ (w[t - 2] >> 10);
            w[t] = w[t - 16] + s0 + w[t - 7] + s1;
          end
        end
        a = h[0]; b = h[1]; c = h[2]; d = h[3];
        e = h[4]; f = h[5]; g = h[6]; hh = h[7];
        for (int t = 0; t < 64; t++) begin
          s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
          t1 = hh + s1 + ((e & f) ^ (~e & g)) + sps_pkg::round_k(6'(t)) + w[t];
          s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
          t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
          hh = g; g = f; f = e; e = d + t1;
          d = c; c = b; b = a; a = t1 + t2;
        end
        h[0] += a; h[1] += b; h[2] += c; h[3] += d;
        h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
      end
      return {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};
    endfunction

    // Notes an accepted input transaction and queues the results it causes.
    function void note_input(sps_pkg::in_item_t it);
      int len, nib;
      logic [63:0] mask, nonce;
      logic [255:0] digest;
      longint unsigned tries;
      sps_pkg::out_item_t r;
      if (it.func == sps_pkg::FUNC_LOAD) begin
        store[load_ptr] = it.data_byte;
        written[load_ptr] = 1;
        load_ptr = load_ptr + 7'd1;
        return;
      end
      len = (msg_len < 9) ? 9 : msg_len;
      nib = (nibbles > 16) ? 16 : nibbles;
      mask = (nib == 0) ? 64'd0 : ~64'd0 << (64 - 4 * nib);
      nonce = it.seed_nonce;
      tries = 0;
      while (tries < longint'(attempt_limit)) begin
        tries++;
        nonce = nonce + 64'd1;
        for (int i = 0; i < 8; i++) begin
          store[len - 8 + i] = nonce[8 * i +: 8];
          written[len - 8 + i] = 1;
        end
        digest = sha256_of_store(len);
        if (((digest[255:192] ^ target) & mask) == 64'd0) begin
          for (int k = 0; k < 4; k++) begin
            r.status = sps_pkg::STATUS_MATCH;
            r.nonce = nonce;
            r.digest_word = digest[255 - 64 * k -: 64];
            r.word_index = 2'(k);
            r.last = (k == 3);
            expected_q = {expected_q, r};
          end
          return;
        end
      end
      r.status = sps_pkg::STATUS_EXHAUSTED;
      r.nonce = nonce;
      r.digest_word = '0;
      r.word_index = '0;
      r.last = 1'b1;
      expected_q = {expected_q, r};
    endfunction

    // Checks one accepted result transaction against the oldest expectation.
    function void check_result(sps_pkg::out_item_t got);
      sps_pkg::out_item_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction %h", got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.status !== exp_r.status) begin
        $error("status expected %h actual %h", exp_r.status, got.status);
        errors++;
      end
      if (got.nonce !== exp_r.nonce) begin
        $error("nonce expected %h actual %h", exp_r.nonce, got.nonce);
        errors++;
      end
      if (got.digest_word !== exp_r.digest_word) begin
        $error("digest_word expected %h actual %h", exp_r.digest_word, got.digest_word);
        errors++;
      end
      if (got.word_index !== exp_r.word_index) begin
        $error("word_index expected %h actual %h", exp_r.word_index, got.word_index);
        errors++;
      end
      if (got.last !== exp_r.last) begin
        $error("last expected %h actual %h", exp_r.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  sps_pkg::in_item_t  in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  sps_pkg::out_item_t out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  nonce_search_scoreboard sb = new();
  bit quiet = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int idle_count = 0;
  int items_sent = 0;

  sha256_prefix_nonce_search dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Result side: check accepted transactions and stall at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
    if (hold_req) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 9);
    end
  end

  // Watchdog: counts cycles in which no channel moves a transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_item(sps_pkg::in_item_t it);
    if (!quiet && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic load_byte(logic [7:0] b);
    sps_pkg::in_item_t it;
    it = '0;
    it.func = sps_pkg::FUNC_LOAD;
    it.data_byte = b;
    it.seed_nonce = {$urandom, $urandom};
    send_item(it);
  endtask

  task automatic search(logic [63:0] start);
    sps_pkg::in_item_t it;
    it.func = sps_pkg::FUNC_SEARCH;
    it.data_byte = 8'($urandom);
    it.seed_nonce = start;
    send_item(it);
  endtask

  // Waits until no result is outstanding and the block has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [6:0] len, logic [4:0] nib, logic [63:0] tv,
                           logic [31:0] att);
    write_reg(sps_pkg::REG_MESSAGE_LENGTH, 64'(len));
    write_reg(sps_pkg::REG_TARGET_NIBBLES, 64'(nib));
    write_reg(sps_pkg::REG_TARGET_VALUE, tv);
    write_reg(sps_pkg::REG_MAX_ATTEMPTS, 64'(att));
  endtask

  initial begin
    int phase, n_items, maxl;
    logic [4:0] nib;
    logic [31:0] att;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: shortest message, any digest matches, nonce wrap.
    configure(7'd0, 5'd0, 64'd0, 32'd1);
    load_byte(8'hFF);
    load_byte(8'h00);
    search(64'd0);
    search(64'hFFFF_FFFF_FFFF_FFFF);
    wait_idle();
    // Zero attempts gives an immediate exhausted result.
    configure(7'd9, 5'd16, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    search(64'h8000_0000_0000_0000);
    wait_idle();
    // Full width target and a wide nibble count, both exhausted.
    write_reg(sps_pkg::REG_MAX_ATTEMPTS, 64'd3);
    search(64'h0123_4567_89AB_CDEF);
    wait_idle();
    write_reg(sps_pkg::REG_TARGET_NIBBLES, 64'd31);
    search(64'hFFFF_FFFF_FFFF_FFFE);
    wait_idle();
    // Largest attempt limit with no nibbles to compare matches at once.
    configure(7'd12, 5'd0, 64'd0, 32'hFFFF_FFFF);
    load_byte(8'h80);
    load_byte(8'h55);
    load_byte(8'hAA);
    load_byte(8'h01);
    search(64'd5);
    wait_idle();
    configure(7'd13, 5'd1, 64'h0, 32'd40);
    search(64'd0);
    wait_idle();

    // Random phases.
    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      quiet = (phase == 3);
      maxl = sb.longest_safe_length();
      case ($urandom_range(0, 9))
        0: begin nib = 5'($urandom_range(3, 31)); att = $urandom_range(0, 3); end
        1: begin nib = 5'd0; att = $urandom; end
        2: begin nib = 5'd2; att = $urandom_range(1, 8); end
        default: begin nib = 5'($urandom_range(0, 1)); att = $urandom_range(1, 6); end
      endcase
      if (phase % 5 == 4) configure(7'(maxl), nib, {$urandom, $urandom}, att);
      else configure(7'($urandom_range(0, maxl)), nib, {$urandom, $urandom}, att);
      if (phase == 2) hold_req = 1;
      n_items = $urandom_range(15, 40);
      for (int i = 0; i < n_items; i++) begin
        if (phase == 2 && i < 8) search({$urandom, $urandom});
        else if ($urandom_range(0, 99) < 70) load_byte(8'($urandom));
        else if ($urandom_range(0, 9) == 0) search(64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 3));
        else search({$urandom, $urandom});
      end
      wait_idle();
      phase++;
    end

    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
